// ===== design/pspec_pkg.sv =====
// Package for the printf conversion specifier parser.
// Holds the character codes, scan mode codes and modifier codes shared by the design.
// No dependencies.
package pspec_pkg;

  // Scan mode codes
  localparam logic [1:0] MODE_GENERAL = 2'd0;
  localparam logic [1:0] MODE_WIDTH   = 2'd1;
  localparam logic [1:0] MODE_DOT     = 2'd2;
  localparam logic [1:0] MODE_PREC    = 2'd3;

  // Pending single length modifier
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_H    = 2'd1;
  localparam logic [1:0] PEND_L    = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // Flag bit positions
  localparam int FLAG_ALT   = 0;
  localparam int FLAG_ZPAD  = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_PLUS  = 3;
  localparam int FLAG_SPACE = 4;

  // Length bit positions
  localparam int LEN_HH = 0;
  localparam int LEN_H  = 1;
  localparam int LEN_LL = 2;
  localparam int LEN_L  = 3;
  localparam int LEN_J  = 4;
  localparam int LEN_Z  = 5;

  // Precision reported when a dot precision is zero, whether from zero digits or a bare dot
  localparam logic [16:0] PREC_ZERO_CODE = 17'h1FFFF;

  typedef logic [4:0] flag_bits_t;
  typedef logic [5:0] len_bits_t;

endpackage

// ===== design/printf_spec_parser_core.sv =====
// Printf conversion spec parser: input register, combinational update logic, result register.
// A terminating character passes the input register, then the result register.
// One character per cycle unless stalled; the parse state update is a single registered pass.
// Reset (rst_n low, synchronous): parse state cleared to general mode, both stages empty.
// Depends on pspec_pkg.
module printf_spec_parser_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_ch,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_conversion,
  output logic                out_hit_end,
  output pspec_pkg::flag_bits_t out_flag_bits,
  output pspec_pkg::len_bits_t  out_length_bits,
  output logic [15:0]         out_field_width,
  output logic                out_width_from_arg,
  output logic signed [16:0]  out_prec_value,
  output logic                out_prec_given,
  output logic                out_prec_from_arg
);
  import pspec_pkg::*;

  localparam int ACC_BITS = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_go;
  logic       s1_fire;

  // Parse state
  logic [1:0]            mode_r, mode_nxt;
  logic [1:0]            pend_r, pend_nxt;
  flag_bits_t            flags_r, flags_nxt;
  len_bits_t             len_r, len_nxt;
  logic [COUNT_BITS-1:0] wcnt_r, wcnt_nxt;
  logic                  wstar_r, wstar_nxt;
  logic [COUNT_BITS-1:0] pcnt_r, pcnt_nxt;
  logic                  pseen_r, pseen_nxt;
  logic                  pstar_r, pstar_nxt;

  // Result stage
  logic out_valid_r;
  logic emit;
  logic [7:0]  res_conv;
  flag_bits_t  res_flags;
  len_bits_t   res_len;
  logic [15:0] res_width;
  logic        res_wstar;
  logic [16:0] res_prec;
  logic        res_pseen;
  logic        res_pstar;

  // Decimal accumulate with saturation
  function automatic logic [COUNT_BITS-1:0] add_digit(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [7:0] c);
    logic [ACC_BITS-1:0] sum;
    logic [7:0]          dig;
    begin
      dig = c - CH_ZERO;
      sum = (ACC_BITS'(acc) << 3) + (ACC_BITS'(acc) << 1) + ACC_BITS'(dig[3:0]);
      if (sum[ACC_BITS-1:COUNT_BITS] != '0) begin
        add_digit = COUNT_MAX;
      end else begin
        add_digit = sum[COUNT_BITS-1:0];
      end
    end
  endfunction

  // Handshake: the input stage moves on whenever the result register can take a result
  assign s1_go    = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign out_valid = out_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_ch_r <= in_ch;
    end
  end

  // Parse logic for one character
  always_comb begin
    logic        is_dig;
    logic        do_general;
    logic        skip;
    logic [31:0] wext;
    logic [31:0] pext;

    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    flags_nxt = flags_r;
    len_nxt   = len_r;
    wcnt_nxt  = wcnt_r;
    wstar_nxt = wstar_r;
    pcnt_nxt  = pcnt_r;
    pseen_nxt = pseen_r;
    pstar_nxt = pstar_r;
    emit      = 1'b0;
    skip      = 1'b0;
    do_general = 1'b1;
    is_dig    = (s1_ch_r >= CH_ZERO) && (s1_ch_r <= CH_NINE);

    // Mode-specific handling before the general path
    unique case (mode_r)
      MODE_WIDTH: begin
        if (is_dig) begin
          wcnt_nxt   = add_digit(wcnt_r, s1_ch_r);
          do_general = 1'b0;
        end else begin
          mode_nxt = MODE_GENERAL;
        end
      end
      MODE_PREC: begin
        if (is_dig) begin
          pcnt_nxt   = add_digit(pcnt_r, s1_ch_r);
          do_general = 1'b0;
        end else begin
          mode_nxt = MODE_GENERAL;
        end
      end
      MODE_DOT: begin
        mode_nxt = MODE_GENERAL;
        if (s1_ch_r == CH_STAR) begin
          pstar_nxt  = 1'b1;
          do_general = 1'b0;
        end else begin
          pseen_nxt = 1'b1;
          pcnt_nxt  = '0;
          if (is_dig) begin
            pcnt_nxt   = add_digit('0, s1_ch_r);
            mode_nxt   = MODE_PREC;
            do_general = 1'b0;
          end
        end
      end
      default: begin
        mode_nxt = MODE_GENERAL;
      end
    endcase

    // General path: resolve a pending modifier first
    if (do_general) begin
      if (pend_r == PEND_H) begin
        pend_nxt = PEND_NONE;
        if (s1_ch_r == CH_H) begin
          len_nxt[LEN_HH] = 1'b1;
          skip = 1'b1;
        end else begin
          len_nxt[LEN_H] = 1'b1;
        end
      end else if (pend_r == PEND_L) begin
        pend_nxt = PEND_NONE;
        if (s1_ch_r == CH_L) begin
          len_nxt[LEN_LL] = 1'b1;
          skip = 1'b1;
        end else begin
          len_nxt[LEN_L] = 1'b1;
        end
      end

      if (!skip) begin
        priority if (s1_ch_r == CH_HASH)  flags_nxt[FLAG_ALT]   = 1'b1;
        else if (s1_ch_r == CH_ZERO)      flags_nxt[FLAG_ZPAD]  = 1'b1;
        else if (s1_ch_r == CH_MINUS)     flags_nxt[FLAG_LEFT]  = 1'b1;
        else if (s1_ch_r == CH_PLUS)      flags_nxt[FLAG_PLUS]  = 1'b1;
        else if (s1_ch_r == CH_SPACE)     flags_nxt[FLAG_SPACE] = 1'b1;
        else if (s1_ch_r == CH_STAR)      wstar_nxt = 1'b1;
        else if (s1_ch_r == CH_DOT)       mode_nxt  = MODE_DOT;
        else if (s1_ch_r == CH_H)         pend_nxt  = PEND_H;
        else if (s1_ch_r == CH_L)         pend_nxt  = PEND_L;
        else if (s1_ch_r == CH_J)         len_nxt[LEN_J] = 1'b1;
        else if (s1_ch_r == CH_Z)         len_nxt[LEN_Z] = 1'b1;
        else if (is_dig) begin
          wcnt_nxt = add_digit('0, s1_ch_r);
          mode_nxt = MODE_WIDTH;
        end else begin
          emit = 1'b1;
        end
      end
    end

    // Result fields, taken from the state as it stands at the terminator
    wext      = 32'(wcnt_nxt);
    pext      = 32'(pcnt_nxt);
    res_conv  = s1_ch_r;
    res_flags = flags_nxt;
    res_len   = len_nxt;
    res_width = wext[15:0];
    res_wstar = wstar_nxt;
    res_prec  = (pseen_nxt && (pcnt_nxt == '0)) ? PREC_ZERO_CODE : pext[16:0];
    res_pseen = pseen_nxt;
    res_pstar = pstar_nxt;

    // Terminator clears the whole specification
    if (emit) begin
      mode_nxt  = MODE_GENERAL;
      pend_nxt  = PEND_NONE;
      flags_nxt = '0;
      len_nxt   = '0;
      wcnt_nxt  = '0;
      wstar_nxt = 1'b0;
      pcnt_nxt  = '0;
      pseen_nxt = 1'b0;
      pstar_nxt = 1'b0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_GENERAL;
      pend_r  <= PEND_NONE;
      flags_r <= '0;
      len_r   <= '0;
      wcnt_r  <= '0;
      wstar_r <= 1'b0;
      pcnt_r  <= '0;
      pseen_r <= 1'b0;
      pstar_r <= 1'b0;
    end else if (s1_fire) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      flags_r <= flags_nxt;
      len_r   <= len_nxt;
      wcnt_r  <= wcnt_nxt;
      wstar_r <= wstar_nxt;
      pcnt_r  <= pcnt_nxt;
      pseen_r <= pseen_nxt;
      pstar_r <= pstar_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_conversion     <= res_conv;
      out_hit_end        <= (res_conv == CH_NUL);
      out_flag_bits      <= res_flags;
      out_length_bits    <= res_len;
      out_field_width    <= res_width;
      out_width_from_arg <= res_wstar;
      out_prec_value     <= $signed(res_prec);
      out_prec_given     <= res_pseen;
      out_prec_from_arg  <= res_pstar;
    end
  end

endmodule

// ===== tb/sv/printf_spec_parser_core_tb.sv =====
// Self-checking testbench for printf_spec_parser_core: streams format characters, predicts each
// parsed conversion spec in a scoreboard class and checks every result field by field.
// Depends on pspec_pkg and printf_spec_parser_core.
module printf_spec_parser_core_tb;
  import pspec_pkg::*;

  localparam int COUNT_BITS   = 16;
  localparam int STREAM_LEN   = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 40;

  // One parsed conversion spec, as it leaves the block
  typedef struct packed {
    logic [7:0]  conversion;
    logic        hit_end;
    flag_bits_t  flag_bits;
    len_bits_t   length_bits;
    logic [15:0] field_width;
    logic        width_from_arg;
    logic [16:0] prec_value;
    logic        prec_given;
    logic        prec_from_arg;
  } spec_t;

  // Parser model plus queue of specs still owed by the block
  class spec_scoreboard;
    spec_t       expected_specs[$];
    int          failures;
    logic [1:0]  mode;
    logic [1:0]  pend;
    flag_bits_t  flags;
    len_bits_t   lens;
    logic [15:0] width_cnt;
    logic [15:0] prec_cnt;
    bit          width_star;
    bit          prec_dot;
    bit          prec_star;

    function new();
      failures = 0;
      clear_spec();
    endfunction

    function void clear_spec();
      mode       = MODE_GENERAL;
      pend       = PEND_NONE;
      flags      = '0;
      lens       = '0;
      width_cnt  = '0;
      prec_cnt   = '0;
      width_star = 1'b0;
      prec_dot   = 1'b0;
      prec_star  = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Decimal accumulate, saturating at 2^COUNT_BITS - 1
    function logic [15:0] add_digit(logic [15:0] acc, logic [7:0] c);
      longint v;
      v = longint'(acc) * 10 + longint'(c) - longint'(CH_ZERO);
      if (v > (64'd1 << COUNT_BITS) - 1) v = (64'd1 << COUNT_BITS) - 1;
      return v[15:0];
    endfunction

    // Advance the parse by one accepted character
    function void note_char(logic [7:0] c);
      spec_t r;
      case (mode)
        MODE_WIDTH: begin
          if (is_digit(c)) begin
            width_cnt = add_digit(width_cnt, c);
            return;
          end
        end
        MODE_PREC: begin
          if (is_digit(c)) begin
            prec_cnt = add_digit(prec_cnt, c);
            return;
          end
        end
        MODE_DOT: begin
          if (c == CH_STAR) begin
            mode      = MODE_GENERAL;
            prec_star = 1'b1;
            return;
          end
          prec_dot = 1'b1;
          prec_cnt = '0;
          if (is_digit(c)) begin
            prec_cnt = add_digit('0, c);
            mode     = MODE_PREC;
            return;
          end
        end
        default: ;
      endcase
      mode = MODE_GENERAL;

      // a lone h or l waits one character for its twin
      if (pend == PEND_H) begin
        pend = PEND_NONE;
        if (c == CH_H) begin
          lens[LEN_HH] = 1'b1;
          return;
        end
        lens[LEN_H] = 1'b1;
      end else if (pend == PEND_L) begin
        pend = PEND_NONE;
        if (c == CH_L) begin
          lens[LEN_LL] = 1'b1;
          return;
        end
        lens[LEN_L] = 1'b1;
      end

      case (c)
        CH_HASH:  flags[FLAG_ALT]   = 1'b1;
        CH_ZERO:  flags[FLAG_ZPAD]  = 1'b1;
        CH_MINUS: flags[FLAG_LEFT]  = 1'b1;
        CH_PLUS:  flags[FLAG_PLUS]  = 1'b1;
        CH_SPACE: flags[FLAG_SPACE] = 1'b1;
        CH_STAR:  width_star = 1'b1;
        CH_DOT:   mode = MODE_DOT;
        CH_H:     pend = PEND_H;
        CH_L:     pend = PEND_L;
        CH_J:     lens[LEN_J] = 1'b1;
        CH_Z:     lens[LEN_Z] = 1'b1;
        default: begin
          if (is_digit(c)) begin
            width_cnt = add_digit('0, c);
            mode      = MODE_WIDTH;
          end else begin
            // terminator: emit the spec and start afresh
            r.conversion     = c;
            r.hit_end        = (c == CH_NUL);
            r.flag_bits      = flags;
            r.length_bits    = lens;
            r.field_width    = width_cnt;
            r.width_from_arg = width_star;
            r.prec_value     = (prec_dot && prec_cnt == '0) ? PREC_ZERO_CODE : {1'b0, prec_cnt};
            r.prec_given     = prec_dot;
            r.prec_from_arg  = prec_star;
            expected_specs.push_back(r);
            clear_spec();
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic signed [17:0] want, logic signed [17:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Check one transaction from the result channel against the oldest expectation
    function void check_spec(spec_t got);
      spec_t want;
      if (expected_specs.size() == 0) begin
        $error("result with nothing expected, conversion %0d", got.conversion);
        failures++;
        return;
      end
      want = expected_specs.pop_front();
      compare_field("conversion", want.conversion, got.conversion);
      compare_field("hit_end", want.hit_end, got.hit_end);
      compare_field("flag_bits", want.flag_bits, got.flag_bits);
      compare_field("length_bits", want.length_bits, got.length_bits);
      compare_field("field_width", want.field_width, got.field_width);
      compare_field("width_from_arg", want.width_from_arg, got.width_from_arg);
      compare_field("prec_value", $signed(want.prec_value), $signed(got.prec_value));
      compare_field("prec_given", want.prec_given, got.prec_given);
      compare_field("prec_from_arg", want.prec_from_arg, got.prec_from_arg);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_conversion;
  logic        out_hit_end;
  flag_bits_t  out_flag_bits;
  len_bits_t   out_length_bits;
  logic [15:0] out_field_width;
  logic        out_width_from_arg;
  logic signed [16:0] out_prec_value;
  logic        out_prec_given;
  logic        out_prec_from_arg;

  spec_scoreboard sb = new();
  logic [7:0]     char_stream[$];
  int             idle_cycles = 0;

  printf_spec_parser_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_ch              (in_ch),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_conversion     (out_conversion),
    .out_hit_end        (out_hit_end),
    .out_flag_bits      (out_flag_bits),
    .out_length_bits    (out_length_bits),
    .out_field_width    (out_field_width),
    .out_width_from_arg (out_width_from_arg),
    .out_prec_value     (out_prec_value),
    .out_prec_given     (out_prec_given),
    .out_prec_from_arg  (out_prec_from_arg)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle draw: a random idle gap, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 11))
      0:       return CH_HASH;
      1:       return CH_ZERO;
      2:       return CH_MINUS;
      3:       return CH_PLUS;
      4:       return CH_SPACE;
      5:       return CH_STAR;
      6:       return CH_DOT;
      7:       return CH_H;
      8:       return CH_L;
      9:       return CH_J;
      10:      return CH_Z;
      default: return CH_ZERO + 8'($urandom_range(1, 9));
    endcase
  endfunction

  function automatic bit is_special(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_HASH || c == CH_MINUS ||
           c == CH_PLUS || c == CH_SPACE || c == CH_STAR || c == CH_DOT ||
           c == CH_H || c == CH_L || c == CH_J || c == CH_Z;
  endfunction

  function automatic logic [7:0] pick_conversion();
    string      letters;
    logic [7:0] c;
    letters = "diouxXfFeEgGaAcspn%";
    case ($urandom_range(0, 9))
      0: return CH_NUL;
      1, 2: begin
        do c = 8'($urandom_range(0, 255)); while (is_special(c));
        return c;
      end
      default: return letters[$urandom_range(0, letters.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(0, 4))
      0:       return CH_HASH;
      1:       return CH_ZERO;
      2:       return CH_MINUS;
      3:       return CH_PLUS;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic push_text(string s);
    foreach (s[i]) char_stream.push_back(s[i]);
  endtask

  task automatic push_digits(int n, bit nonzero_lead);
    for (int i = 0; i < n; i++)
      char_stream.push_back(CH_ZERO + ((i == 0 && nonzero_lead) ? 8'($urandom_range(1, 9))
                                                                : 8'($urandom_range(0, 9))));
  endtask

  // A mostly well-formed spec with random content
  task automatic push_spec();
    int nflags;
    nflags = $urandom_range(0, 3);
    repeat (nflags) char_stream.push_back(pick_special() == CH_STAR ? CH_STAR :
                                          (CH_SPACE == 0 ? CH_SPACE : pick_flag()));
    case ($urandom_range(0, 3))
      0: ;
      1: char_stream.push_back(CH_STAR);
      default: begin
        push_digits(($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3), 1);
        if ($urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1)) char_stream.push_back(pick_flag());
          push_digits($urandom_range(1, 3), 1);
        end
      end
    endcase
    case ($urandom_range(0, 4))
      0, 1: ;
      2: begin
        char_stream.push_back(CH_DOT);
        char_stream.push_back(CH_STAR);
      end
      3: char_stream.push_back(CH_DOT);
      default: begin
        char_stream.push_back(CH_DOT);
        push_digits(($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3), 0);
      end
    endcase
    case ($urandom_range(0, 7))
      2: push_text("hh");
      3: char_stream.push_back(CH_H);
      4: push_text("ll");
      5: char_stream.push_back(CH_L);
      6: char_stream.push_back(CH_J);
      7: char_stream.push_back(CH_Z);
      default: ;
    endcase
    char_stream.push_back(pick_conversion());
  endtask

  // Broken sequences: any byte at all, weighted towards spec characters
  task automatic push_noise();
    repeat ($urandom_range(1, 8))
      char_stream.push_back($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
  endtask

  // Observe both channels at the same edge, input side first
  always @(posedge clk) begin
    spec_t got;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) sb.note_char(in_ch);
      if (out_valid && !out_stall) begin
        got.conversion     = out_conversion;
        got.hit_end        = out_hit_end;
        got.flag_bits      = out_flag_bits;
        got.length_bits    = out_length_bits;
        got.field_width    = out_field_width;
        got.width_from_arg = out_width_from_arg;
        got.prec_value     = out_prec_value;
        got.prec_given     = out_prec_given;
        got.prec_from_arg  = out_prec_from_arg;
        sb.check_spec(got);
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall per transaction, one long hold-off to back up the input
  initial begin
    int gap;
    int calm;
    int taken;
    calm  = 0;
    taken = 0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = (taken == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus and end of run
  initial begin
    int gap;
    int calm;
    calm = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_ch    <= '0;

    // directed: all flags, zero inside a width run, zero precision, hh
    push_text("#0- +*10.0hhx");
    // saturating width, dot-star, later width run, j, lone l before z, top byte
    push_text("99999.*7jlz");
    char_stream.push_back(8'hFF);
    // repeated dot restarts precision, lone h closed by the NUL terminator
    push_text(".5.h");
    char_stream.push_back(CH_NUL);

    while (char_stream.size() < STREAM_LEN) begin
      if ($urandom_range(0, 6) == 0) push_noise();
      else push_spec();
    end
    push_text("d");

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (char_stream[i]) begin
      gap = draw_gap(calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_ch    <= char_stream[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (sb.expected_specs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.failures == 0 && sb.expected_specs.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== printf_spec_parser_core.f =====
design/pspec_pkg.sv
design/printf_spec_parser_core.sv
tb/sv/printf_spec_parser_core_tb.sv
